[hdl/crlc_pkg.sv]
package crlc_pkg;

   // Item operations, carried on req_tuser
   typedef enum logic [2:0] {
      OP_AUTO_UPDATE = 3'd0,
      OP_LATCH_CHECK = 3'd1,
      OP_MANUAL_SET  = 3'd2,
      OP_FORCE_OFF   = 3'd3,
      OP_SET_AUTO    = 3'd4
   } op_type;

   // Configuration register indexes
   typedef enum logic [1:0] {
      CSR_ON_DELAY   = 2'd0,
      CSR_OFF_DELAY  = 2'd1,
      CSR_LATCH_MODE = 2'd2,
      CSR_ACTIVE_LOW = 2'd3
   } csr_index_type;

   // Latch modes; the unused code behaves as no latch
   localparam logic [1:0] LATCH_NONE   = 2'd0;
   localparam logic [1:0] LATCH_PULSE  = 2'd1;
   localparam logic [1:0] LATCH_FOLLOW = 2'd2;

   localparam int unsigned TIME_W = 32;

endpackage

[hdl/contactor_relay_latch_controller.sv]
// Contactor relay controller with optional bistable latch pulse requests.
// Input channel (req_): one item per transfer; req_tuser holds the operation,
// req_tdata holds the one-bit argument and the millisecond timestamp.
// Result channel (rsp_): exactly one result per item, in item order, giving
// the relay state, the pin level, SET/RESET pulse requests and the auto flag.
// Configuration (csr_): one register written per cycle with csr_wr_en high;
// write only while no item is in flight.
// Flow: an accepted item is captured in the input register, evaluated
// against the controller state by one 32-bit subtract and compare, and its
// result is registered in the result register once that stage can advance;
// the result register then offers it on rsp_.
// Throughput: one item per cycle while rsp_tready stays high; the state
// update and the delay compare of the evaluation stage bound it.
// Reset (synchronous) clears both stages and loads relay off, auto following
// on, latch tracker uninitialised and all delays and modes zero.
// When the receiver stalls the result register holds, the input register
// fills, and req_tready falls once both stages are occupied.
module contactor_relay_latch_controller (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // [0] bit_arg, [32:1] now_ms, [39:33] zero
   input  logic [2:0]  req_tuser,   // [2:0] operation
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [0] relay_on, [1] pin_level, [2] set_pulse,
                                    // [3] reset_pulse, [4] auto_on, [7:5] zero
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   localparam int unsigned TW = crlc_pkg::TIME_W;

   // configuration
   logic [TW-1:0] on_delay_ff;
   logic [TW-1:0] off_delay_ff;
   logic [1:0]    latch_mode_ff;
   logic          active_low_ff;

   // input stage
   logic             in_valid_ff, in_valid_in;
   crlc_pkg::op_type op_ff;
   logic             arg_ff;
   logic [TW-1:0]    now_ff;

   // controller state
   logic          relay_ff,    relay_in;
   logic          auto_ff,     auto_in;
   logic          ready_ff,    ready_in;
   logic          last_ff,     last_in;
   logic          waiting_ff,  waiting_in;
   logic          pending_ff,  pending_in;
   logic [TW-1:0] start_ff,    start_in;

   // result stage
   logic out_valid_ff, out_valid_in;
   logic out_relay_ff, out_pin_ff, out_set_ff, out_reset_ff, out_auto_ff;
   logic set_p, reset_p;

   logic advance;
   logic accept;
   logic [TW-1:0] wait_ms;
   logic [TW-1:0] elapsed;

   assign advance    = !out_valid_ff || rsp_tready;
   assign req_tready = !in_valid_ff || advance;
   assign accept     = req_tvalid && req_tready;

   assign in_valid_in  = accept || (in_valid_ff && !advance);
   assign out_valid_in = advance ? in_valid_ff : out_valid_ff;

   always_comb begin
      relay_in   = relay_ff;
      auto_in    = auto_ff;
      ready_in   = ready_ff;
      last_in    = last_ff;
      waiting_in = waiting_ff;
      pending_in = pending_ff;
      start_in   = start_ff;
      set_p      = 1'b0;
      reset_p    = 1'b0;
      wait_ms    = '0;
      elapsed    = '0;
      case (op_ff)
         crlc_pkg::OP_AUTO_UPDATE: begin
            if (auto_ff) begin
               relay_in = arg_ff;
            end
         end
         crlc_pkg::OP_LATCH_CHECK: begin
            if (latch_mode_ff == crlc_pkg::LATCH_FOLLOW) begin
               if (!ready_ff) begin
                  last_in  = arg_ff;
                  ready_in = 1'b1;
               end else if (arg_ff == last_ff) begin
                  // drop a wait toward the other level
                  if (waiting_ff && (pending_ff != arg_ff)) begin
                     waiting_in = 1'b0;
                  end
               end else begin
                  if (!waiting_ff || (pending_ff != arg_ff)) begin
                     pending_in = arg_ff;
                     start_in   = now_ff;
                     waiting_in = 1'b1;
                  end
                  wait_ms = pending_in ? on_delay_ff : off_delay_ff;
                  elapsed = now_ff - start_in;
                  if (elapsed >= wait_ms) begin
                     set_p      = pending_in;
                     reset_p    = !pending_in;
                     last_in    = pending_in;
                     waiting_in = 1'b0;
                  end
               end
            end
         end
         crlc_pkg::OP_MANUAL_SET: begin
            auto_in = 1'b0;
            if (relay_ff != arg_ff) begin
               relay_in = arg_ff;
               if (latch_mode_ff == crlc_pkg::LATCH_PULSE) begin
                  set_p   = arg_ff;
                  reset_p = !arg_ff;
               end
            end
         end
         crlc_pkg::OP_FORCE_OFF: begin
            relay_in = 1'b0;
            if ((latch_mode_ff == crlc_pkg::LATCH_PULSE) ||
                (latch_mode_ff == crlc_pkg::LATCH_FOLLOW)) begin
               reset_p = 1'b1;
            end
            if (latch_mode_ff == crlc_pkg::LATCH_FOLLOW) begin
               waiting_in = 1'b0;
               pending_in = 1'b0;
               last_in    = 1'b0;
               ready_in   = 1'b1;
               start_in   = now_ff;
            end
         end
         crlc_pkg::OP_SET_AUTO: begin
            auto_in = arg_ff;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         on_delay_ff   <= '0;
         off_delay_ff  <= '0;
         latch_mode_ff <= crlc_pkg::LATCH_NONE;
         active_low_ff <= 1'b0;
      end else if (csr_wr_en) begin
         case (crlc_pkg::csr_index_type'(csr_index))
            crlc_pkg::CSR_ON_DELAY:   on_delay_ff   <= csr_wdata[TW-1:0];
            crlc_pkg::CSR_OFF_DELAY:  off_delay_ff  <= csr_wdata[TW-1:0];
            crlc_pkg::CSR_LATCH_MODE: latch_mode_ff <= csr_wdata[1:0];
            crlc_pkg::CSR_ACTIVE_LOW: active_low_ff <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         relay_ff     <= 1'b0;
         auto_ff      <= 1'b1;
         ready_ff     <= 1'b0;
         last_ff      <= 1'b0;
         waiting_ff   <= 1'b0;
         pending_ff   <= 1'b0;
         start_ff     <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         // commit state only as the item moves into the result register
         if (in_valid_ff && advance) begin
            relay_ff   <= relay_in;
            auto_ff    <= auto_in;
            ready_ff   <= ready_in;
            last_ff    <= last_in;
            waiting_ff <= waiting_in;
            pending_ff <= pending_in;
            start_ff   <= start_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff  <= crlc_pkg::op_type'(req_tuser);
         arg_ff <= req_tdata[0];
         now_ff <= req_tdata[TW:1];
      end
      if (in_valid_ff && advance) begin
         out_relay_ff <= relay_in;
         out_pin_ff   <= relay_in ^ active_low_ff;
         out_set_ff   <= set_p;
         out_reset_ff <= reset_p;
         out_auto_ff  <= auto_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {3'b000, out_auto_ff, out_reset_ff, out_set_ff,
                        out_pin_ff, out_relay_ff};

`ifndef SYNTHESIS
   a_one_pulse_line : assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> !(out_set_ff && out_reset_ff))
      else $error("both latch pulse lines requested together");

   a_wait_needs_ready : assert property (@(posedge clock) disable iff (reset)
      waiting_ff |-> ready_ff)
      else $error("latch tracker waiting before it was initialised");

   a_accept_fills_input : assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> in_valid_ff)
      else $error("accepted item lost from input register");
`endif

endmodule

[sim/tb_top.sv]
module tb_top;

   // Operation codes that the block must leave without effect
   localparam logic [2:0] OP_UNKNOWN_FIRST = 3'd5;
   localparam logic [2:0] OP_UNKNOWN_LAST  = 3'd7;
   localparam logic [1:0] LATCH_UNUSED     = 2'd3;
   localparam int LONG_HOLD_CYCLES = 120;
   localparam int MAX_REPORTS      = 10;

   class relay_scoreboard;
      logic [31:0] on_delay;
      logic [31:0] off_delay;
      logic [1:0]  latch_mode;
      logic        active_low;
      logic        relay_on;
      logic        auto_en;
      logic        trk_ready;
      logic        trk_level;
      logic        trk_waiting;
      logic        trk_target;
      logic [31:0] wait_start;
      logic [7:0]  expected_q[$];
      int unsigned noted;
      int unsigned errors;

      function new();
         on_delay    = '0;
         off_delay   = '0;
         latch_mode  = crlc_pkg::LATCH_NONE;
         active_low  = 1'b0;
         relay_on    = 1'b0;
         auto_en     = 1'b1;
         trk_ready   = 1'b0;
         trk_level   = 1'b0;
         trk_waiting = 1'b0;
         trk_target  = 1'b0;
         wait_start  = '0;
         noted       = 0;
         errors      = 0;
      endfunction

      function void load_reg(crlc_pkg::csr_index_type idx, logic [31:0] value);
         case (idx)
            crlc_pkg::CSR_ON_DELAY:   on_delay   = value;
            crlc_pkg::CSR_OFF_DELAY:  off_delay  = value;
            crlc_pkg::CSR_LATCH_MODE: latch_mode = value[1:0];
            crlc_pkg::CSR_ACTIVE_LOW: active_low = value[0];
            default: ;
         endcase
      endfunction

      // Delayed SET/RESET request of the latch-follow tracker
      function void track_latch(input logic charging, input logic [31:0] stamp,
                                output logic set_p, output logic reset_p);
         logic [31:0] hold_ms;
         set_p   = 1'b0;
         reset_p = 1'b0;
         if (latch_mode != crlc_pkg::LATCH_FOLLOW)
            return;
         if (!trk_ready) begin
            trk_level = charging;
            trk_ready = 1'b1;
            return;
         end
         if (charging == trk_level) begin
            // state went back: drop the waiting request
            if (trk_waiting && trk_target != charging)
               trk_waiting = 1'b0;
            return;
         end
         if (!trk_waiting || trk_target != charging) begin
            trk_target  = charging;
            wait_start  = stamp;
            trk_waiting = 1'b1;
         end
         hold_ms = trk_target ? on_delay : off_delay;
         if (stamp - wait_start < hold_ms)
            return;
         set_p       = trk_target;
         reset_p     = !trk_target;
         trk_level   = trk_target;
         trk_waiting = 1'b0;
      endfunction

      function void note_transfer(logic [2:0] op, logic arg, logic [31:0] stamp);
         logic set_p;
         logic reset_p;
         set_p   = 1'b0;
         reset_p = 1'b0;
         case (op)
            crlc_pkg::OP_AUTO_UPDATE: if (auto_en) relay_on = arg;
            crlc_pkg::OP_LATCH_CHECK: track_latch(arg, stamp, set_p, reset_p);
            crlc_pkg::OP_MANUAL_SET: begin
               auto_en = 1'b0;
               if (relay_on != arg) begin
                  relay_on = arg;
                  if (latch_mode == crlc_pkg::LATCH_PULSE) begin
                     set_p   = arg;
                     reset_p = !arg;
                  end
               end
            end
            crlc_pkg::OP_FORCE_OFF: begin
               relay_on = 1'b0;
               if (latch_mode == crlc_pkg::LATCH_PULSE ||
                   latch_mode == crlc_pkg::LATCH_FOLLOW)
                  reset_p = 1'b1;
               if (latch_mode == crlc_pkg::LATCH_FOLLOW) begin
                  trk_waiting = 1'b0;
                  trk_target  = 1'b0;
                  trk_level   = 1'b0;
                  trk_ready   = 1'b1;
                  wait_start  = stamp;
               end
            end
            crlc_pkg::OP_SET_AUTO: auto_en = arg;
            default: ;
         endcase
         expected_q.push_back({3'b000, auto_en, reset_p, set_p, relay_on ^ active_low,
                               relay_on});
         noted++;
      endfunction

      function void check_result(logic [7:0] got);
         logic [7:0] want;
         if (expected_q.size() == 0) begin
            errors++;
            if (errors <= MAX_REPORTS)
               $display("result %h arrived with nothing outstanding", got);
            return;
         end
         want = expected_q.pop_front();
         if (got[4:0] !== want[4:0]) begin
            errors++;
            if (errors <= MAX_REPORTS)
               $display("result mismatch: expected %b actual %b (auto reset set pin relay)",
                        want[4:0], got[4:0]);
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   wire         req_tready;
   logic [39:0] req_tdata = '0;
   logic [2:0]  req_tuser = '0;
   wire         rsp_tvalid;
   logic        rsp_tready = 1'b0;
   wire  [7:0]  rsp_tdata;
   logic        csr_wr_en = 1'b0;
   logic [1:0]  csr_index = '0;
   logic [31:0] csr_wdata = '0;

   relay_scoreboard sb;
   int          burst_left = 0;
   logic [31:0] ms_clock = '0;
   logic        charging_now = 1'b0;

   contactor_relay_latch_controller dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Offer one item, with bursts and gaps; returns at the edge of the transfer
   task automatic offer(logic [2:0] op, logic arg, logic [31:0] stamp);
      int gap;
      if (burst_left == 0) begin
         if ($urandom_range(0, 3) == 0) begin
            gap = 0;
            burst_left = $urandom_range(20, 60);
         end else begin
            gap = $urandom_range(0, 6);
            burst_left = $urandom_range(1, 12);
         end
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {7'b0, stamp, arg};
      do @(posedge clock); while (!req_tready);
      sb.note_transfer(op, arg, stamp);
   endtask

   task automatic csr_write(crlc_pkg::csr_index_type idx, logic [31:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      sb.load_reg(idx, value);
      @(posedge clock);
   endtask

   task automatic configure(logic [31:0] on_ms, logic [31:0] off_ms, logic [1:0] mode,
                            logic low);
      csr_write(crlc_pkg::CSR_ON_DELAY, on_ms);
      csr_write(crlc_pkg::CSR_OFF_DELAY, off_ms);
      csr_write(crlc_pkg::CSR_LATCH_MODE, {30'b0, mode});
      csr_write(crlc_pkg::CSR_ACTIVE_LOW, {31'b0, low});
      csr_wr_en <= 1'b0;
   endtask

   // Stop offering and wait until every result is back
   task automatic drain();
      req_tvalid <= 1'b0;
      burst_left = 0;
      while (sb.expected_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Mostly a running clock with a persistent charging state, plus some noise
   task automatic random_items(int count);
      int r;
      logic [31:0] stamp;
      for (int i = 0; i < count; i++) begin
         r = $urandom_range(0, 99);
         if ($urandom_range(0, 49) == 0)
            ms_clock = $urandom;
         else if ($urandom_range(0, 14) == 0)
            ms_clock += $urandom_range(0, 1000);
         else
            ms_clock += $urandom_range(0, 6);
         if ($urandom_range(0, 5) == 0)
            charging_now = ~charging_now;
         stamp = ($urandom_range(0, 19) == 0) ? $urandom : ms_clock;
         if (r < 45)
            offer(crlc_pkg::OP_LATCH_CHECK, charging_now, stamp);
         else if (r < 60)
            offer(crlc_pkg::OP_AUTO_UPDATE, charging_now, stamp);
         else if (r < 70)
            offer(crlc_pkg::OP_MANUAL_SET, 1'($urandom_range(0, 1)), stamp);
         else if (r < 75)
            offer(crlc_pkg::OP_FORCE_OFF, 1'($urandom_range(0, 1)), stamp);
         else if (r < 85)
            offer(crlc_pkg::OP_SET_AUTO, $urandom_range(0, 3) != 0, stamp);
         else if (r < 90)
            offer(3'($urandom_range(OP_UNKNOWN_FIRST, OP_UNKNOWN_LAST)),
                  1'($urandom_range(0, 1)), stamp);
         else
            offer(crlc_pkg::OP_LATCH_CHECK, 1'($urandom_range(0, 1)), $urandom);
      end
   endtask

   // Runs with on delay 5 and off delay 8 in latch-follow mode
   task automatic directed_follow();
      offer(OP_UNKNOWN_FIRST, 1'b0, 32'h0000_0000);
      offer(OP_UNKNOWN_FIRST + 3'd1, 1'b1, 32'hFFFF_FFFF);
      offer(OP_UNKNOWN_LAST, 1'b1, 32'h0000_0001);
      offer(crlc_pkg::OP_AUTO_UPDATE, 1'b1, 32'd1);
      offer(crlc_pkg::OP_AUTO_UPDATE, 1'b0, 32'd2);
      offer(crlc_pkg::OP_LATCH_CHECK, 1'b1, 32'd100);   // first check only records
      offer(crlc_pkg::OP_LATCH_CHECK, 1'b0, 32'd101);   // start waiting for RESET
      offer(crlc_pkg::OP_LATCH_CHECK, 1'b1, 32'd104);   // back again: cancel
      offer(crlc_pkg::OP_LATCH_CHECK, 1'b0, 32'd110);
      offer(crlc_pkg::OP_LATCH_CHECK, 1'b0, 32'd118);   // off delay reached
      offer(crlc_pkg::OP_LATCH_CHECK, 1'b1, 32'd120);
      offer(crlc_pkg::OP_LATCH_CHECK, 1'b1, 32'd125);   // on delay reached
      offer(crlc_pkg::OP_SET_AUTO, 1'b0, 32'd126);
      offer(crlc_pkg::OP_AUTO_UPDATE, 1'b1, 32'd127);   // ignored with auto off
      offer(crlc_pkg::OP_MANUAL_SET, 1'b1, 32'd128);
      offer(crlc_pkg::OP_MANUAL_SET, 1'b1, 32'd129);
      offer(crlc_pkg::OP_FORCE_OFF, 1'b0, 32'd200);
      offer(crlc_pkg::OP_SET_AUTO, 1'b1, 32'd201);
      offer(crlc_pkg::OP_AUTO_UPDATE, 1'b1, 32'd202);
      offer(crlc_pkg::OP_LATCH_CHECK, 1'b1, 32'hFFFF_FFFE);
      offer(crlc_pkg::OP_LATCH_CHECK, 1'b1, 32'd3);     // elapsed time across the wrap
      offer(crlc_pkg::OP_FORCE_OFF, 1'b1, 32'hFFFF_FFFF);
   endtask

   // Runs with both delays at their maximum
   task automatic directed_max_delay();
      offer(crlc_pkg::OP_FORCE_OFF, 1'b0, 32'd5);
      offer(crlc_pkg::OP_LATCH_CHECK, 1'b1, 32'd0);
      offer(crlc_pkg::OP_LATCH_CHECK, 1'b1, 32'hFFFF_FFFF);
      offer(crlc_pkg::OP_LATCH_CHECK, 1'b0, 32'd7);
      offer(crlc_pkg::OP_LATCH_CHECK, 1'b0, 32'd6);
   endtask

   initial begin : stimulus
      sb = new();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      random_items(150);
      drain();

      configure(32'd5, 32'd8, crlc_pkg::LATCH_FOLLOW, 1'b0);
      directed_follow();
      random_items(200);
      drain();

      configure(32'd0, 32'd0, crlc_pkg::LATCH_FOLLOW, 1'b1);
      random_items(170);
      drain();

      configure($urandom, $urandom, crlc_pkg::LATCH_PULSE, 1'b1);
      random_items(170);
      drain();

      configure(32'hFFFF_FFFF, 32'hFFFF_FFFF, crlc_pkg::LATCH_FOLLOW, 1'b0);
      directed_max_delay();
      random_items(120);
      drain();

      configure($urandom_range(0, 30), $urandom_range(0, 30), LATCH_UNUSED, 1'b0);
      random_items(130);
      drain();

      ms_clock = 32'hFFFF_FF00;
      configure($urandom_range(0, 30), $urandom_range(0, 30), crlc_pkg::LATCH_FOLLOW,
                1'($urandom_range(0, 1)));
      random_items(230);
      drain();

      configure(32'd1, 32'd50000, crlc_pkg::LATCH_FOLLOW, 1'b1);
      random_items(150);
      drain();

      configure(32'd0, 32'd0, crlc_pkg::LATCH_NONE, 1'b0);
      random_items(80);
      drain();

      repeat (10) @(posedge clock);
      if (sb.errors == 0 && sb.expected_q.size() == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

   initial begin : result_sink
      int rx_cycles;
      int holds_done;
      rx_cycles  = 0;
      holds_done = 0;
      forever begin
         @(posedge clock);
         rx_cycles++;
         if (!reset && rsp_tvalid === 1'b1 && rsp_tready)
            sb.check_result(rsp_tdata);
         // hold off for a long stretch so the block fills and stalls its input
         if ((holds_done == 0 && sb.noted >= 300) || (holds_done == 1 && sb.noted >= 900)) begin
            holds_done++;
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
         end
         case ((rx_cycles / 150) % 4)
            0: rsp_tready <= 1'b1;
            1: rsp_tready <= 1'($urandom_range(0, 1));
            2: rsp_tready <= ($urandom_range(0, 3) == 0);
            default: rsp_tready <= rx_cycles[2];
         endcase
      end
   end

   initial begin : watchdog
      #3000000;
      $display("simulation failed");
      $finish;
   end

endmodule
